@@ src/srxl2_control_frame_receiver_macros.svh @@
// Assertion macros for the checker file.
`ifndef SRXL2_CONTROL_FRAME_RECEIVER_MACROS_SVH
`define SRXL2_CONTROL_FRAME_RECEIVER_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SRXL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SRXL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ src/srxl_pkg.sv @@
// Package with payload types, codes and defaults of the frame receiver.
package srxl_pkg;
    localparam int ChannelsDefault = 32;
    localparam int MaxFrameDefault = 80;

    localparam logic [2:0] ST_CTRL_OK  = 3'd0;
    localparam logic [2:0] ST_HS_OK    = 3'd1;
    localparam logic [2:0] ST_OTHER    = 3'd2;
    localparam logic [2:0] ST_BAD_CRC  = 3'd3;
    localparam logic [2:0] ST_ZERO_CRC = 3'd4;
    localparam logic [2:0] ST_BAD_LEN  = 3'd5;

    localparam logic [1:0] CFG_HEADER    = 2'd0;
    localparam logic [1:0] CFG_CTRL_TYPE = 2'd1;
    localparam logic [1:0] CFG_HS_TYPE   = 2'd2;
    localparam logic [1:0] CFG_MIN_LEN   = 2'd3;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       burst_end;
    } in_item_t;

    typedef struct packed {
        logic        record_kind;
        logic [2:0]  status;
        logic [7:0]  type_seen;
        logic [6:0]  rssi_percent;
        logic [15:0] frame_drop_count;
        logic [5:0]  chan_total;
        logic [4:0]  channel_index;
        logic [15:0] channel_value;
        logic        value_fresh;
        logic        last;
    } out_item_t;

    // One byte step of CRC-16, polynomial 0x1021, MSB first.
    function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
        end
        return c;
    endfunction
endpackage

@@ src/srxl_ram.sv @@
// Generic single-port-write RAM with registered read.
module srxl_ram #(
    parameter int Width = 16,
    parameter int Depth = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ src/srxl2_control_frame_receiver.sv @@
// Top level of the control frame receiver.
// Usage: bytes enter on s_ (rx_byte, burst_end) under valid/ready, one byte
// per item. Configuration registers are written on the cfg_ channel (index
// 0 header, 1 control type, 2 handshake type, 3 minimum length); the user
// must write them only while idle, the block itself does not enforce it.
// A byte that produces nothing leaves s_ready high and the next byte may
// follow at once. A bad length or an early burst end gives its status item
// in the cycle after the byte is taken. A byte that ends a frame moves to
// S_STAT, which decides the status and registers the status item. A good
// control frame with channels present then walks the channel slots through
// the staging and channel memories: S_WALK skips an empty slot or reads a
// staged channel, S_EMIT writes back a fresh value and emits it, using the
// single read port of each memory. No byte is taken during the walk.
// Results leave through one output register; a stalled m_ready holds the
// item and the walk, and s_ready stays low until the result is taken.
// After reset a clearing pass writes 65535 into every channel slot before
// the first byte is accepted. Configuration writes are taken at any time.
module srxl2_control_frame_receiver #(
    parameter int CHANNELS        = srxl_pkg::ChannelsDefault,
    parameter int MAX_FRAME_BYTES = srxl_pkg::MaxFrameDefault
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  srxl_pkg::in_item_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output srxl_pkg::out_item_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);
    import srxl_pkg::*;

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_STAT  = 5'b00100,
        S_WALK  = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_TYPE = 2'd1;
    localparam logic [1:0] PH_LEN  = 2'd2;
    localparam logic [1:0] PH_BODY = 2'd3;

    state_t state_reg;
    logic [7:0]  hdr_reg, ctype_reg, htype_reg;
    logic [6:0]  minlen_reg;
    logic [1:0]  phase_reg;
    logic [7:0]  pos_reg;
    logic [7:0]  len_reg, type_reg, rssi_p_reg, low_reg;
    logic [15:0] crc_reg, crcr_reg, drops_p_reg;
    logic [31:0] mask_reg;
    logic [CHANNELS-1:0] present_reg;
    logic [6:0]  rssi_reg;
    logic [15:0] drops_reg;
    logic [5:0]  count_reg;
    logic [CW:0] idx_reg;
    logic [CW:0] last_ch_reg;
    logic        out_v_reg;
    out_item_t   out_reg;

    // Memories: staged values (11 bits + zero flag as 0) and channel store.
    logic          st_we;
    logic [CW-1:0] st_waddr;
    logic [10:0]   st_wdata, st_rdata;
    logic          ch_we;
    logic [CW-1:0] ch_waddr;
    logic [15:0]   ch_wdata, ch_rdata;
    logic [CW-1:0] rd_addr;

    srxl_ram #(.Width(11), .Depth(CHANNELS)) u_stage (
        .aclk(aclk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(rd_addr), .rdata(st_rdata));
    srxl_ram #(.Width(16), .Depth(CHANNELS)) u_store (
        .aclk(aclk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
        .raddr(rd_addr), .rdata(ch_rdata));

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE) && !out_v_reg;
    assign m_valid   = out_v_reg;
    assign m_data    = out_reg;

    logic accept;
    assign accept = s_valid && s_ready;

    // Byte decode.
    logic [7:0]  b;
    logic [6:0]  minlen;
    logic [8:0]  p2;
    logic [15:0] raw;
    logic        raw_ok;
    logic [15:0] conv;
    logic [CW:0] first_bit;
    logic        any_bit;
    always_comb begin
        b      = s_data.rx_byte;
        minlen = (minlen_reg < 7'd5) ? 7'd5 : minlen_reg;
        p2     = {1'b0, pos_reg} + 9'd2;
        raw    = {b, low_reg};
        raw_ok = (raw >= 16'h1000) && (raw <= 16'hF000);
        conv   = {6'd0, raw[15:6]} + 16'd1000;
        first_bit = '0;
        any_bit   = 1'b0;
        for (int i = CHANNELS - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                first_bit = (CW+1)'(i);
                any_bit   = 1'b1;
            end
        end
    end

    // Write ports. While an item waits in S_EMIT the read address stays on
    // its slot, so the read data hold through a stall.
    always_comb begin
        st_we    = 1'b0;
        st_waddr = first_bit[CW-1:0];
        st_wdata = raw_ok ? conv[10:0] : 11'd0;
        ch_we    = 1'b0;
        ch_waddr = idx_reg[CW-1:0];
        ch_wdata = 16'hFFFF;
        rd_addr  = idx_reg[CW-1:0];
        if (state_reg == S_CLEAR) begin
            ch_we = 1'b1;
        end else if (state_reg == S_EMIT) begin
            rd_addr  = idx_reg[CW-1:0] - CW'(1);
            ch_waddr = idx_reg[CW-1:0] - CW'(1);
            ch_wdata = {5'd0, st_rdata};
            ch_we    = (st_rdata != 11'd0);
        end
        if (accept && phase_reg == PH_BODY && p2 < {1'b0, len_reg}
            && pos_reg >= 8'd12 && pos_reg[0] == 1'b1 && any_bit) begin
            st_we = 1'b1;
        end
    end

    // Status and the base fields of an output item.
    function automatic out_item_t mk(input logic kind, input logic [2:0] st,
                                     input logic [7:0] ty, input logic [6:0] rs,
                                     input logic [15:0] dr, input logic [5:0] cn,
                                     input logic lst);
        out_item_t o;
        o = '0;
        o.record_kind = kind; o.status = st; o.type_seen = ty;
        o.rssi_percent = rs; o.frame_drop_count = dr; o.chan_total = cn;
        o.last = lst;
        return o;
    endfunction

    logic [CW:0] hi_ch;
    always_comb begin
        hi_ch = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (present_reg[i]) hi_ch = (CW+1)'(i);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            hdr_reg <= 8'hA6; ctype_reg <= 8'hCD; htype_reg <= 8'h21;
            minlen_reg <= 7'd5;
            phase_reg <= PH_HUNT;
            pos_reg <= '0; len_reg <= '0; type_reg <= '0; crc_reg <= '0;
            crcr_reg <= '0; mask_reg <= '0; rssi_p_reg <= '0;
            drops_p_reg <= '0; low_reg <= '0; present_reg <= '0;
            rssi_reg <= '0; drops_reg <= '0; count_reg <= '0;
            idx_reg <= '0; last_ch_reg <= '0;
            out_v_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_HEADER:    hdr_reg <= cfg_data;
                    CFG_CTRL_TYPE: ctype_reg <= cfg_data;
                    CFG_HS_TYPE:   htype_reg <= cfg_data;
                    CFG_MIN_LEN:   minlen_reg <= cfg_data[6:0];
                    default:       hdr_reg <= hdr_reg;
                endcase
            end
            if (out_v_reg && m_ready) out_v_reg <= 1'b0;
            case (state_reg)
                S_CLEAR: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == (CW+1)'(CHANNELS - 1)) begin
                        idx_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        case (phase_reg)
                            PH_HUNT: begin
                                if (b == hdr_reg) begin
                                    pos_reg <= 8'd1; len_reg <= '0; type_reg <= '0;
                                    crc_reg <= crc_add(16'd0, b); crcr_reg <= '0;
                                    mask_reg <= '0; rssi_p_reg <= '0;
                                    drops_p_reg <= '0; low_reg <= '0;
                                    present_reg <= '0;
                                    phase_reg <= PH_TYPE;
                                end
                            end
                            PH_TYPE: begin
                                type_reg <= b; crc_reg <= crc_add(crc_reg, b);
                                pos_reg <= 8'd2; phase_reg <= PH_LEN;
                            end
                            PH_LEN: begin
                                len_reg <= b; crc_reg <= crc_add(crc_reg, b);
                                pos_reg <= 8'd3; phase_reg <= PH_BODY;
                                if ({1'b0, b} < {2'b00, minlen}
                                    || {1'b0, b} > 9'(MAX_FRAME_BYTES)) begin
                                    phase_reg <= PH_HUNT;
                                    out_v_reg <= 1'b1;
                                    out_reg <= mk(1'b0, ST_BAD_LEN, type_reg, rssi_reg,
                                                  drops_reg, count_reg, 1'b1);
                                end
                            end
                            default: begin
                                pos_reg <= pos_reg + 8'd1;
                                if (p2 < {1'b0, len_reg}) begin
                                    crc_reg <= crc_add(crc_reg, b);
                                    if (pos_reg == 8'd5) rssi_p_reg <= b;
                                    else if (pos_reg == 8'd6) drops_p_reg <= {b, 8'd0};
                                    else if (pos_reg == 8'd7) drops_p_reg[7:0] <= b;
                                    else if (pos_reg >= 8'd8 && pos_reg <= 8'd11) begin
                                        case (pos_reg[1:0])
                                            2'd0: mask_reg[7:0] <= b;
                                            2'd1: mask_reg[15:8] <= b;
                                            2'd2: mask_reg[23:16] <= b;
                                            default: mask_reg[31:24] <= b;
                                        endcase
                                    end else if (pos_reg >= 8'd12) begin
                                        if (pos_reg[0] == 1'b0) low_reg <= b;
                                        else if (any_bit) begin
                                            mask_reg[first_bit[CW-1:0]] <= 1'b0;
                                            present_reg[first_bit[CW-1:0]] <= 1'b1;
                                        end
                                    end
                                end else if (p2 == {1'b0, len_reg}) begin
                                    crcr_reg <= {b, 8'd0};
                                end else begin
                                    crcr_reg[7:0] <= b;
                                    phase_reg <= PH_HUNT;
                                    state_reg <= S_STAT;
                                end
                            end
                        endcase
                        if (s_data.burst_end && !(phase_reg == PH_HUNT && b != hdr_reg)
                            && !(phase_reg == PH_LEN && ({1'b0, b} < {2'b00, minlen}
                                 || {1'b0, b} > 9'(MAX_FRAME_BYTES)))
                            && !(phase_reg == PH_BODY && p2 > {1'b0, len_reg})) begin
                            phase_reg <= PH_HUNT;
                            out_v_reg <= 1'b1;
                            out_reg <= mk(1'b0, ST_BAD_LEN,
                                          (phase_reg == PH_HUNT) ? 8'd0
                                          : (phase_reg == PH_TYPE) ? b : type_reg,
                                          rssi_reg, drops_reg, count_reg, 1'b1);
                        end
                    end
                end
                S_STAT: begin
                    // Decide the status and update the held values.
                    logic [2:0] st;
                    logic [6:0] rs;
                    logic [5:0] cn;
                    logic [15:0] dr;
                    st = (crcr_reg == 16'd0) ? ST_ZERO_CRC
                       : (crcr_reg != crc_reg) ? ST_BAD_CRC
                       : (type_reg == ctype_reg) ? ST_CTRL_OK
                       : (type_reg == htype_reg) ? ST_HS_OK : ST_OTHER;
                    rs = rssi_reg; dr = drops_reg; cn = count_reg;
                    if (st == ST_HS_OK) cn = '0;
                    if (st == ST_CTRL_OK) begin
                        if (rssi_p_reg >= 8'd1 && rssi_p_reg <= 8'd127) rs = rssi_p_reg[6:0];
                        dr = drops_p_reg;
                        if ((present_reg != '0) && (6'(hi_ch) + 6'd1 > cn))
                            cn = 6'(hi_ch) + 6'd1;
                    end
                    rssi_reg <= rs; drops_reg <= dr; count_reg <= cn;
                    last_ch_reg <= hi_ch;
                    out_v_reg <= 1'b1;
                    out_reg <= mk(1'b0, st, type_reg, rs, dr, cn,
                                  !((st == ST_CTRL_OK) && (present_reg != '0)));
                    idx_reg <= '0;
                    state_reg <= ((st == ST_CTRL_OK) && (present_reg != '0)) ? S_WALK : S_IDLE;
                end
                S_WALK: begin
                    // Issue the read of slot idx; skip empty slots.
                    if (present_reg[idx_reg[CW-1:0]]) begin
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= S_EMIT;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                default: begin
                    // Read data for slot idx-1 is here: write back and emit.
                    if (!out_v_reg || m_ready) begin
                        out_v_reg <= 1'b1;
                        out_reg <= mk(1'b1, ST_CTRL_OK, type_reg, rssi_reg,
                                      drops_reg, count_reg,
                                      (idx_reg - 1'b1) == last_ch_reg);
                        out_reg.channel_index <= 5'(idx_reg - 1'b1);
                        out_reg.channel_value <= (st_rdata != 11'd0)
                                                 ? {5'd0, st_rdata} : ch_rdata;
                        out_reg.value_fresh <= (st_rdata != 11'd0);
                        state_reg <= ((idx_reg - 1'b1) == last_ch_reg) ? S_IDLE : S_WALK;
                    end
                end
            endcase
        end
    end
endmodule

@@ src/srxl_checker.sv @@
// Port-level checker for the frame receiver, bound to the top level.
`include "srxl2_control_frame_receiver_macros.svh"
module srxl_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input srxl_pkg::out_item_t m_data
);
    import srxl_pkg::*;

    // A stalled result holds.
    `SRXL_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    // No byte is taken while a result waits.
    `SRXL_ASSERT_IMP(a_block, aclk, aresetn, m_valid, !s_ready)
    // Channel items carry status zero; status items carry no fresh flag.
    `SRXL_ASSERT_IMP(a_kind, aclk, aresetn, m_valid && m_data.record_kind,
                     m_data.status == ST_CTRL_OK)
    `SRXL_ASSERT_IMP(a_stat, aclk, aresetn, m_valid && !m_data.record_kind,
                     !m_data.value_fresh && m_data.channel_index == 5'd0)
endmodule

bind srxl2_control_frame_receiver srxl_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data));
